// ===== rtl/tsacq_pkg.sv =====
// Shared constants for the touch sample averaging and event queue block.
`timescale 1ns / 1ps

package tsacq_pkg;

  // Block sizing.
  localparam int EVENT_TABLE_SIZE = 16;
  localparam int SAMPLE_COUNT     = 10;
  localparam int RING_SLOTS       = EVENT_TABLE_SIZE - 1;
  localparam int PTR_W            = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int CNT_W            = $clog2(SAMPLE_COUNT + 1);

  // Field widths.
  localparam int RAW_W  = 8;
  localparam int CAL_W  = 8;
  localparam int SUM_W  = 12;
  localparam int COL_W  = 8;
  localparam int ROW_W  = 9;
  localparam int OCOL_W = 9;
  localparam int OROW_W = 10;
  localparam int CFG_INDEX_W = 2;

  // Divide by ten as a multiply by a reciprocal; exact for sums below 16384.
  localparam int AVG_RECIP_SHIFT = 15;
  localparam int AVG_RECIP       = 3277;
  localparam int RECIP_W         = 12;
  localparam int PROD_W          = SUM_W + RECIP_W;
  localparam int AVG_W           = 9;

  // Scaling constants.
  localparam int X_SCALE = 320;
  localparam int Y_SCALE = 240;
  localparam int X_BIAS  = 3;
  localparam int SCALE_W = 9;
  localparam int NUM_W   = AVG_W + 2;
  localparam int DVD_W   = AVG_W + SCALE_W;
  localparam int STEP_W  = $clog2(DVD_W + 1);

  // Calibration register resets.
  localparam logic [CAL_W-1:0] X_MIN_RESET = CAL_W'(8);
  localparam logic [CAL_W-1:0] X_MAX_RESET = CAL_W'(116);
  localparam logic [CAL_W-1:0] Y_MIN_RESET = CAL_W'(9);
  localparam logic [CAL_W-1:0] Y_MAX_RESET = CAL_W'(113);

  // Operation codes.
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_X_MIN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_X_MAX = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_MIN = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_MAX = 2'd3;

endpackage

// ===== rtl/touch_sample_average_calibrate_queue_core.sv =====
// Touch sample averaging, calibration and event ring, top level.
//
// Channel | Direction | Handshake          | Payload
// input   | in        | in_valid/in_ready   | opcode, raw_x, raw_y, pen_down
// result  | out       | out_valid/out_ready | event_col, event_row, queue_empty
// config  | in        | cfg_write           | cfg_index, cfg_data
//
// A sample, release tick or ignored code is handled in the idle state. The sample that
// completes a set goes on to average, to form the scaled numerators, to run the
// bit-serial restoring dividers and to write the ring.
// A read waits in the read state for the registered read port of the ring memory,
// and holds there while the previous result transaction has not been taken.
// Reset is synchronous; the ring memory itself is not cleared.
`timescale 1ns / 1ps

module touch_sample_average_calibrate_queue_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           opcode,
  input  logic [tsacq_pkg::RAW_W-1:0]          raw_x,
  input  logic [tsacq_pkg::RAW_W-1:0]          raw_y,
  input  logic                                 pen_down,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tsacq_pkg::OCOL_W-1:0]  event_col,
  output logic signed [tsacq_pkg::OROW_W-1:0]  event_row,
  output logic                                 queue_empty,
  input  logic                                 cfg_write,
  input  logic [tsacq_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tsacq_pkg::CAL_W-1:0]          cfg_data
);
  import tsacq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG,
    S_SCALE,
    S_DIV,
    S_PUSH,
    S_READ
  } state_t;

  localparam int ENTRY_W = COL_W + ROW_W;

  state_t state;

  logic [CAL_W-1:0] x_min, x_max, y_min, y_max;
  logic [PTR_W-1:0] write_pointer, read_pointer;
  logic             lockout;
  logic [SUM_W-1:0] sum_x, sum_y;
  logic [CNT_W-1:0] samples_taken;
  logic [AVG_W-1:0] avg_x, avg_y;
  logic [DVD_W-1:0] dvd_x, dvd_y;
  logic [CAL_W-1:0] rem_x, rem_y;
  logic [CAL_W-1:0] span_x, span_y;
  logic             sat_x, sat_y;
  logic [STEP_W-1:0] step;
  logic             read_empty;

  // Ring memory with a registered read port.
  logic [ENTRY_W-1:0] ring_mem [RING_SLOTS];
  logic [ENTRY_W-1:0] rd_data;
  logic               mem_we;
  logic [ENTRY_W-1:0] mem_wdata;

  logic               accept;
  logic [SUM_W-1:0]   sum_x_add, sum_y_add;
  logic               last_sample;
  logic [PROD_W-1:0]  prod_x, prod_y;
  logic signed [NUM_W-1:0] num_x, num_y;
  logic [DVD_W-1:0]   scaled_x, scaled_y;
  logic [CAL_W:0]     trial_x, trial_y;
  logic               ge_x, ge_y;
  logic [SCALE_W-1:0] sx, sy;
  logic [COL_W-1:0]   col_val;
  logic [ROW_W-1:0]   row_val;
  logic [PTR_W-1:0]   wp_next, rp_next;
  logic               out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Accumulate the incoming pair.
  assign sum_x_add   = sum_x + SUM_W'(raw_x);
  assign sum_y_add   = sum_y + SUM_W'(raw_y);
  assign last_sample = (samples_taken == CNT_W'(SAMPLE_COUNT - 1));

  // Average by reciprocal multiply.
  assign prod_x = PROD_W'(sum_x) * PROD_W'(AVG_RECIP);
  assign prod_y = PROD_W'(sum_y) * PROD_W'(AVG_RECIP);

  // Offset numerators and scaled dividends.
  always_comb begin
    num_x = $signed(NUM_W'(avg_x)) - $signed(NUM_W'(x_min)) + NUM_W'(X_BIAS);
    num_y = $signed(NUM_W'(avg_y)) - $signed(NUM_W'(y_min));
    scaled_x = DVD_W'(num_x[AVG_W-1:0]) * DVD_W'(X_SCALE);
    scaled_y = DVD_W'(num_y[AVG_W-1:0]) * DVD_W'(Y_SCALE);
  end

  // One restoring divide step per axis.
  always_comb begin
    trial_x = {rem_x, dvd_x[DVD_W-1]};
    trial_y = {rem_y, dvd_y[DVD_W-1]};
    ge_x    = (trial_x >= {1'b0, span_x});
    ge_y    = (trial_y >= {1'b0, span_y});
  end

  // Clamp, mirror and pack the event.
  always_comb begin
    sx = (sat_x || (dvd_x > DVD_W'(X_SCALE))) ? SCALE_W'(X_SCALE) : dvd_x[SCALE_W-1:0];
    sy = (sat_y || (dvd_y > DVD_W'(Y_SCALE))) ? SCALE_W'(Y_SCALE) : dvd_y[SCALE_W-1:0];
    row_val   = ROW_W'(SCALE_W'(X_SCALE) - sx);
    col_val   = COL_W'(SCALE_W'(Y_SCALE) - sy);
    mem_wdata = {col_val, row_val};
    mem_we    = (state == S_PUSH);
  end

  // Ring pointers wrap at the slot count.
  assign wp_next = (write_pointer == PTR_W'(RING_SLOTS - 1)) ? '0 : write_pointer + 1'b1;
  assign rp_next = (read_pointer == PTR_W'(RING_SLOTS - 1)) ? '0 : read_pointer + 1'b1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[write_pointer] <= mem_wdata;
    end
    rd_data <= ring_mem[read_pointer];
  end

  // Calibration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_min <= X_MIN_RESET;
      x_max <= X_MAX_RESET;
      y_min <= Y_MIN_RESET;
      y_max <= Y_MAX_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_X_MIN: x_min <= cfg_data;
        REG_X_MAX: x_max <= cfg_data;
        REG_Y_MIN: y_min <= cfg_data;
        REG_Y_MAX: y_max <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      write_pointer <= '0;
      read_pointer  <= '0;
      lockout       <= 1'b0;
      sum_x         <= '0;
      sum_y         <= '0;
      samples_taken <= '0;
      out_valid     <= 1'b0;
      step          <= '0;
    end else begin
      // A taken result is dropped unless the read state issues the next one.
      if (out_valid && out_ready && (state != S_READ)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (opcode)
              OP_SAMPLE: begin
                if (pen_down && !lockout) begin
                  sum_x <= sum_x_add;
                  sum_y <= sum_y_add;
                  if (last_sample) begin
                    state <= S_AVG;
                  end else begin
                    samples_taken <= samples_taken + 1'b1;
                  end
                end
              end
              OP_RELEASE: lockout <= 1'b0;
              OP_READ: begin
                read_empty <= (write_pointer == read_pointer);
                state      <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_AVG: begin
          avg_x <= prod_x[AVG_RECIP_SHIFT +: AVG_W];
          avg_y <= prod_y[AVG_RECIP_SHIFT +: AVG_W];
          state <= S_SCALE;
        end
        S_SCALE: begin
          sat_x  <= (x_max <= x_min) || num_x[NUM_W-1];
          sat_y  <= (y_max <= y_min) || num_y[NUM_W-1];
          span_x <= x_max - x_min;
          span_y <= y_max - y_min;
          dvd_x  <= scaled_x;
          dvd_y  <= scaled_y;
          rem_x  <= '0;
          rem_y  <= '0;
          step   <= '0;
          state  <= S_DIV;
        end
        S_DIV: begin
          rem_x <= ge_x ? CAL_W'(trial_x - {1'b0, span_x}) : CAL_W'(trial_x);
          rem_y <= ge_y ? CAL_W'(trial_y - {1'b0, span_y}) : CAL_W'(trial_y);
          dvd_x <= {dvd_x[DVD_W-2:0], ge_x};
          dvd_y <= {dvd_y[DVD_W-2:0], ge_y};
          step  <= step + 1'b1;
          if (step == STEP_W'(DVD_W - 1)) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          write_pointer <= wp_next;
          lockout       <= 1'b1;
          sum_x         <= '0;
          sum_y         <= '0;
          samples_taken <= '0;
          state         <= S_IDLE;
        end
        S_READ: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            queue_empty <= read_empty;
            if (read_empty) begin
              event_col <= '1;
              event_row <= '1;
            end else begin
              event_col    <= OCOL_W'(rd_data[ROW_W +: COL_W]);
              event_row    <= OROW_W'(rd_data[ROW_W-1:0]);
              read_pointer <= rp_next;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the touch sample averaging, calibration and event ring block.
`timescale 1ns / 1ps

module tb_top;
  import tsacq_pkg::*;

  // Code that the block ignores.
  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam int AVG_DIVISOR   = 10;
  localparam int RANDOM_ITEMS  = 900;
  localparam int DRAIN_CYCLES  = 30;
  localparam int CYCLE_LIMIT   = 400000;

  // One read result as the block presents it.
  typedef struct packed {
    logic signed [OCOL_W-1:0] col;
    logic signed [OROW_W-1:0] row;
    logic                     empty;
  } touch_event_t;

  // Tracks calibration, averaging and the event ring, and checks read results in order.
  class touch_event_scoreboard;
    bit [CAL_W-1:0]   cal [4];
    logic [COL_W-1:0] col_ring [RING_SLOTS];
    logic [ROW_W-1:0] row_ring [RING_SLOTS];
    int unsigned      wr_ptr;
    int unsigned      rd_ptr;
    bit               locked;
    logic [SUM_W-1:0] acc_x;
    logic [SUM_W-1:0] acc_y;
    int unsigned      taken;
    touch_event_t     expected_reads [$];
    int               failures;

    function new();
      cal[REG_X_MIN] = X_MIN_RESET;
      cal[REG_X_MAX] = X_MAX_RESET;
      cal[REG_Y_MIN] = Y_MIN_RESET;
      cal[REG_Y_MAX] = Y_MAX_RESET;
      wr_ptr = 0;
      rd_ptr = 0;
      locked = 1'b0;
      acc_x = '0;
      acc_y = '0;
      taken = 0;
      failures = 0;
    endfunction

    function void write_cal(logic [CFG_INDEX_W-1:0] idx, logic [CAL_W-1:0] val);
      cal[idx] = val;
    endfunction

    function int pending();
      return expected_reads.size();
    endfunction

    // Scales one averaged axis; a negative numerator or a bad span saturates to full scale.
    function int calibrate_axis(int avg, int lo, int hi, int bias, int full);
      int num;
      int q;
      num = avg - lo + bias;
      if (hi <= lo || num < 0) return full;
      q = (num * full) / (hi - lo);
      return (q > full) ? full : q;
    endfunction

    function int unsigned ring_next(int unsigned p);
      return (p + 1 >= RING_SLOTS) ? 0 : p + 1;
    endfunction

    // Applies one accepted input transaction; returns 1 when the block acted on it.
    function bit take_input(logic [1:0] op, logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry,
                            logic pen);
      touch_event_t ev;
      int sx;
      int sy;
      case (op)
        OP_SAMPLE: begin
          if (!pen || locked) return 1'b0;
          acc_x = acc_x + SUM_W'(rx);
          acc_y = acc_y + SUM_W'(ry);
          if (taken + 1 >= SAMPLE_COUNT) begin
            sx = calibrate_axis(int'(acc_x) / AVG_DIVISOR, int'(cal[REG_X_MIN]),
                                int'(cal[REG_X_MAX]), X_BIAS, X_SCALE);
            sy = calibrate_axis(int'(acc_y) / AVG_DIVISOR, int'(cal[REG_Y_MIN]),
                                int'(cal[REG_Y_MAX]), 0, Y_SCALE);
            col_ring[wr_ptr] = COL_W'(Y_SCALE - sy);
            row_ring[wr_ptr] = ROW_W'(X_SCALE - sx);
            wr_ptr = ring_next(wr_ptr);
            locked = 1'b1;
            acc_x = '0;
            acc_y = '0;
            taken = 0;
          end else begin
            taken++;
          end
          return 1'b1;
        end
        OP_RELEASE: begin
          locked = 1'b0;
          return 1'b1;
        end
        OP_READ: begin
          if (wr_ptr == rd_ptr) begin
            ev.col = '1;
            ev.row = '1;
            ev.empty = 1'b1;
          end else begin
            ev.col = {1'b0, col_ring[rd_ptr]};
            ev.row = {1'b0, row_ring[rd_ptr]};
            ev.empty = 1'b0;
            rd_ptr = ring_next(rd_ptr);
          end
          expected_reads.push_back(ev);
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    // Compares one result transaction with the oldest expected read.
    function void check_result(logic signed [OCOL_W-1:0] col, logic signed [OROW_W-1:0] row,
                               logic empty);
      touch_event_t want;
      if (expected_reads.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("Unexpected result: col %0d row %0d empty %0b", col, row, empty);
        return;
      end
      want = expected_reads.pop_front();
      if (col !== want.col || row !== want.row || empty !== want.empty) begin
        failures++;
        if (failures <= 10)
          $display("Read mismatch: expected col %0d row %0d empty %0b, got col %0d row %0d empty %0b",
                   want.col, want.row, want.empty, col, row, empty);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               opcode = OP_SAMPLE;
  logic [RAW_W-1:0]         raw_x = '0;
  logic [RAW_W-1:0]         raw_y = '0;
  logic                     pen_down = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [OCOL_W-1:0] event_col;
  logic signed [OROW_W-1:0] event_row;
  logic                     queue_empty;
  logic                     cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]   cfg_index = REG_X_MIN;
  logic [CAL_W-1:0]         cfg_data = '0;

  touch_event_scoreboard sb = new();

  int effective_items = 0;
  int burst_left = 0;
  int gap_max = 3;
  int ready_mode = 1;
  int stall_left = 0;

  touch_sample_average_calibrate_queue_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .raw_x      (raw_x),
    .raw_y      (raw_y),
    .pen_down   (pen_down),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_col  (event_col),
    .event_row  (event_row),
    .queue_empty(queue_empty),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: always ready, random stalls, or long stall bursts, by phase.
  always @(posedge clk) begin
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 99) < 60);
      default: begin
        if (stall_left != 0) begin
          stall_left <= stall_left - 1;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(5, 30);
        end
      end
    endcase
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(event_col, event_row, queue_empty);
  end

  // Watchdog.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Presents one input transaction, waits for it to be taken, then maybe leaves a gap.
  task automatic send_item(input logic [1:0] op, input logic [RAW_W-1:0] rx,
                           input logic [RAW_W-1:0] ry, input logic pen);
    in_valid <= 1'b1;
    opcode <= op;
    raw_x <= rx;
    raw_y <= ry;
    pen_down <= pen;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    void'(sb.take_input(op, rx, ry, pen));
    effective_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
  endtask

  // Writes one register; the caller lowers the write enable after the last one.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CAL_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_cal(idx, val);
  endtask

  task automatic load_calibration(input logic [CAL_W-1:0] xmin, input logic [CAL_W-1:0] xmax,
                                  input logic [CAL_W-1:0] ymin, input logic [CAL_W-1:0] ymax);
    write_reg(REG_X_MIN, xmin);
    write_reg(REG_X_MAX, xmax);
    write_reg(REG_Y_MIN, ymin);
    write_reg(REG_Y_MAX, ymax);
    cfg_write <= 1'b0;
  endtask

  // Holds the sender off until every read has returned and the dividers have finished.
  task automatic wait_for_quiet_block();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // An item of random shape, mostly harmless to a set in progress.
  task automatic send_noise(input bit no_reads);
    logic [1:0] op;
    op = 2'($urandom_range(0, 3));
    if (no_reads && op == OP_READ) op = OP_IGNORED;
    send_item(op, RAW_W'($urandom), RAW_W'($urandom), 1'($urandom));
  endtask

  // One slice of traffic: mostly a complete touch set, otherwise reads, ticks or noise.
  task automatic run_touch_sequence(input bit no_reads);
    int kind;
    int n;
    int jit;
    logic [RAW_W-1:0] bx;
    logic [RAW_W-1:0] by;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      if ($urandom_range(0, 99) < 85)
        send_item(OP_RELEASE, RAW_W'($urandom), RAW_W'($urandom), 1'($urandom));
      bx = RAW_W'($urandom);
      by = RAW_W'($urandom);
      case ($urandom_range(0, 3))
        0: jit = 0;
        1: jit = 3;
        2: jit = 15;
        default: jit = 255;
      endcase
      // Now and then a set is cut short; its partial sum carries over.
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, SAMPLE_COUNT - 1) : SAMPLE_COUNT;
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) send_noise(no_reads);
        send_item(OP_SAMPLE, bx ^ RAW_W'($urandom_range(0, jit)),
                  by ^ RAW_W'($urandom_range(0, jit)), 1'b1);
      end
    end else if (kind < 75 && !no_reads) begin
      repeat ($urandom_range(1, 4))
        send_item(OP_READ, RAW_W'($urandom), RAW_W'($urandom), 1'($urandom));
    end else if (kind < 85) begin
      send_item(OP_RELEASE, RAW_W'($urandom), RAW_W'($urandom), 1'($urandom));
    end else begin
      send_noise(no_reads);
    end
  endtask

  initial begin
    int phase;
    int phase_end;
    bit no_reads;
    logic [CAL_W-1:0] lo;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset calibration: empty read, ignored codes,
    // a full set at the raw extremes, a sample during lockout, then a partial set.
    send_item(OP_READ, 8'hFF, 8'hFF, 1'b1);
    send_item(OP_IGNORED, 8'hFF, 8'hFF, 1'b1);
    send_item(OP_RELEASE, 8'h00, 8'h00, 1'b0);
    send_item(OP_SAMPLE, 8'hFF, 8'hFF, 1'b0);
    repeat (SAMPLE_COUNT) send_item(OP_SAMPLE, 8'hFF, 8'h00, 1'b1);
    send_item(OP_SAMPLE, 8'h00, 8'hFF, 1'b1);
    send_item(OP_READ, 8'h00, 8'h00, 1'b0);
    send_item(OP_READ, 8'h00, 8'h00, 1'b0);
    send_item(OP_RELEASE, 8'hFF, 8'hFF, 1'b1);
    repeat (3) send_item(OP_SAMPLE, 8'h00, 8'hFF, 1'b1);

    // Random phases, each under its own calibration and idling pattern.
    effective_items = 0;
    phase = 0;
    while (effective_items < RANDOM_ITEMS) begin
      wait_for_quiet_block();
      lo = CAL_W'($urandom_range(0, 200));
      case (phase % 6)
        0: load_calibration(lo, CAL_W'($urandom_range(lo + 1, 255)),
                            CAL_W'($urandom_range(0, 120)), CAL_W'($urandom_range(121, 255)));
        1: load_calibration(8'h00, 8'hFF, 8'h00, 8'hFF);
        2: load_calibration(8'hFF, 8'h00, lo, lo);
        3: load_calibration(lo, lo + 8'd1, lo, lo + 8'd1);
        4: load_calibration(X_MIN_RESET, X_MAX_RESET, Y_MIN_RESET, Y_MAX_RESET);
        default: load_calibration(CAL_W'($urandom), CAL_W'($urandom),
                                  CAL_W'($urandom), CAL_W'($urandom));
      endcase
      case (phase % 3)
        0: gap_max = 0;
        1: gap_max = 4;
        default: gap_max = 12;
      endcase
      ready_mode <= (phase + 1) % 3;
      // Every sixth phase, from the second on, fills the ring well past its size before reading anything back.
      no_reads = (phase % 6 == 1);
      phase_end = effective_items + (no_reads ? 220 : 110);
      if (phase_end > RANDOM_ITEMS) phase_end = RANDOM_ITEMS;
      while (effective_items < phase_end) run_touch_sequence(no_reads);
      if (no_reads)
        repeat (RING_SLOTS + 3)
          send_item(OP_READ, RAW_W'($urandom), RAW_W'($urandom), 1'($urandom));
      phase++;
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tsacq_pkg.sv
rtl/touch_sample_average_calibrate_queue_core.sv
tb/tb_top.sv
